>>> rtl/rqs_pkg.sv
// Package: shared types, codes and defaults for the ring queue with search.
`default_nettype none
package rqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CAP_W     = 5;
  localparam int WORD_W    = 32;
  localparam int SLOT_W    = 4;

  typedef logic [2:0]               mode_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CAP_W-1:0]         cap_t;
  typedef logic [SLOT_W-1:0]        slot_t;

  localparam mode_t MODE_ENQ   = 3'd0;
  localparam mode_t MODE_DEQ   = 3'd1;
  localparam mode_t MODE_PEEK  = 3'd2;
  localparam mode_t MODE_CLR   = 3'd3;
  localparam mode_t MODE_SRCH  = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

endpackage
`default_nettype wire

>>> rtl/rqs_if.sv
// Interfaces: request and response channels of the ring queue with search.
`default_nettype none
interface rqs_req_if;
  import rqs_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface rqs_rsp_if;
  import rqs_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  word_t   data;
  slot_t   slot;
  cap_t    count;
  logic    is_empty;
  logic    is_full;

  modport source (output valid, output status, output data, output slot, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input data, input slot, input count,
                  input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

>>> rtl/ring_queue_with_search_unit.sv
// Top level: circular word queue with enqueue, dequeue, peek, clear and search.
//
// Requests arrive on in_req (mode, value) and each gives exactly one response
// on out_rsp (status, data, slot, count, is_empty, is_full); a transfer takes
// place when valid and ready are both high. One request is worked on at a time.
// Work per request, accept to ready again: enqueue, clear, failed requests and
// unknown modes go straight to S_FIN; dequeue and peek first do one registered
// read of the slot memory; search compares k entries, at most the fill count,
// one at a time: each is read into a register in S_RD and checked in S_EVAL by
// the one equality comparator. S_FIN loads the response register once work ends.
// The response is held in an output register, so the next request is accepted
// while it waits; if the receiver stalls, the following request finishes and
// then waits until the register is free. cfg_we writes the capacity (0 reads as
// 1, above DEPTH as DEPTH) and empties the queue; write it only while idle.
// Synchronous reset (rst_n low) empties the queue and sets capacity to
// min(16, DEPTH); slot contents are left as they are.
`default_nettype none
module ring_queue_with_search_unit #(
  parameter int DEPTH = rqs_pkg::DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire rqs_pkg::cap_t  cfg_wdata,
  rqs_req_if.sink             in_req,
  rqs_rsp_if.source           out_rsp
);
  import rqs_pkg::*;

  localparam int PW   = $clog2(DEPTH);
  localparam int CMPW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;
  localparam cap_t CAP_RST = cap_t'((DEPTH < 16) ? DEPTH : 16);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EVAL, S_FIN} state_t;
  typedef logic [PW-1:0] ptr_t;

  state_t  state_r, state_nxt;
  ptr_t    head_r, head_nxt, tail_r, tail_nxt, addr_r, addr_nxt;
  cap_t    fill_r, fill_nxt, cap_r, cap_nxt, k_r, k_nxt;
  mode_t   mode_r, mode_nxt;
  word_t   key_r, key_nxt;
  status_t res_status_r, res_status_nxt;
  word_t   res_data_r, res_data_nxt;
  slot_t   res_slot_r, res_slot_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  word_t   out_data_r, out_data_nxt;
  slot_t   out_slot_r, out_slot_nxt;
  cap_t    out_count_r, out_count_nxt;
  logic    out_empty_r, out_empty_nxt, out_full_r, out_full_nxt;

  word_t   slots_r [DEPTH];
  word_t   rd_data_r;
  logic    mem_we;
  logic [31:0] addr_ext;

  function automatic ptr_t wrap_next(input ptr_t p, input cap_t cap);
    logic [CMPW-1:0] n;
    n = CMPW'(p) + CMPW'(1);
    return (n >= CMPW'(cap)) ? '0 : PW'(n);
  endfunction

  assign addr_ext = 32'(addr_r);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    addr_nxt       = addr_r;
    fill_nxt       = fill_r;
    cap_nxt        = cap_r;
    k_nxt          = k_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    mem_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt       = in_req.mode;
          key_nxt        = in_req.value;
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          res_slot_nxt   = '0;
          state_nxt      = S_FIN;
          case (in_req.mode)
            MODE_ENQ: begin
              if (fill_r >= cap_r) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                tail_nxt = wrap_next(tail_r, cap_r);
                fill_nxt = fill_r + cap_t'(1);
              end
            end
            MODE_DEQ, MODE_PEEK: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                addr_nxt  = head_r;
                state_nxt = S_RD;
              end
            end
            MODE_CLR: begin
              head_nxt = '0;
              tail_nxt = '0;
              fill_nxt = '0;
            end
            MODE_SRCH: begin
              if (fill_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                addr_nxt  = head_r;
                k_nxt     = '0;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (mode_r == MODE_SRCH) begin
          if (rd_data_r == key_r) begin
            res_slot_nxt = addr_ext[SLOT_W-1:0];
            state_nxt    = S_FIN;
          end else if (k_r + cap_t'(1) == fill_r) begin
            res_status_nxt = ST_NOTFOUND;
            state_nxt      = S_FIN;
          end else begin
            k_nxt     = k_r + cap_t'(1);
            addr_nxt  = wrap_next(addr_r, cap_r);
            state_nxt = S_RD;
          end
        end else begin
          res_data_nxt = rd_data_r;
          if (mode_r == MODE_DEQ) begin
            head_nxt = wrap_next(head_r, cap_r);
            fill_nxt = fill_r - cap_t'(1);
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_slot_nxt   = res_slot_r;
          out_count_nxt  = fill_r;
          out_empty_nxt  = (fill_r == '0);
          out_full_nxt   = (fill_r == cap_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = cap_t'(1);
      end else if (32'(cfg_wdata) > DEPTH) begin
        cap_nxt = cap_t'(DEPTH);
      end else begin
        cap_nxt = cfg_wdata;
      end
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots_r[tail_r] <= in_req.value;
    end
    rd_data_r <= slots_r[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r       <= addr_nxt;
    k_r          <= k_nxt;
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign in_req.ready     = rst_n && (state_r == S_IDLE);
  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.data     = out_data_r;
  assign out_rsp.slot     = out_slot_r;
  assign out_rsp.count    = out_count_r;
  assign out_rsp.is_empty = out_empty_r;
  assign out_rsp.is_full  = out_full_r;

`ifndef SYNTHESIS
  a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r)
    else $error("fill count above capacity");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CMPW'(head_r) < CMPW'(cap_r)) && (CMPW'(tail_r) < CMPW'(cap_r)))
    else $error("queue pointer outside capacity");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request accepted while previous one in progress");
`endif

endmodule
`default_nettype wire

>>> sim/tb_ring_queue_with_search_unit.sv
// Testbench: directed table then randomised request mix for the ring queue with search.
`default_nettype none
module tb_ring_queue_with_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rqs_pkg::*;

  localparam mode_t MODE_RSVD_LO  = 3'd5;
  localparam mode_t MODE_RSVD_MID = 3'd6;
  localparam mode_t MODE_RSVD_HI  = 3'd7;

  localparam int RESET_CYCLES    = 10;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 116;

  typedef struct packed {
    status_t status;
    word_t   data;
    slot_t   slot;
    cap_t    count;
    logic    is_empty;
    logic    is_full;
  } response_t;

  typedef struct {
    bit        is_cfg;
    cap_t      cfg;
    mode_t     mode;
    word_t     value;
    bit        typed;
    response_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cap_t cfg_wdata;

  rqs_req_if req_if();
  rqs_rsp_if rsp_if();

  ring_queue_with_search_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_rsp   (rsp_if)
  );

  // queue model state
  word_t q_slots [DEPTH_DEF];
  int    q_head;
  int    q_tail;
  int    q_fill;
  int    q_cap;

  response_t pending_rsp [$];
  row_t      dir_rows [$];
  int        error_count;
  int        cycle_count;
  int        sender_idle_pct;
  int        recv_stall_pct;
  int        idle_send [4] = '{0, 66, 0, 34};
  int        idle_recv [4] = '{0, 0, 66, 34};
  cap_t      phase_caps [PHASES] = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd3, 5'd0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ring_queue_with_search_unit: done, errors");
      $finish;
    end
  end

  initial begin
    rsp_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      rsp_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  function automatic int ring_advance(int p);
    return (p + 1 >= q_cap) ? 0 : p + 1;
  endfunction

  function automatic void queue_reinit(cap_t c);
    q_cap  = (c < 1) ? 1 : ((c > DEPTH_DEF) ? DEPTH_DEF : int'(c));
    q_head = 0;
    q_tail = 0;
    q_fill = 0;
  endfunction

  function automatic response_t predict_response(mode_t m, word_t v);
    response_t r;
    int        p;
    bit        hit;
    r = '{status: ST_OK, data: '0, slot: '0, count: '0, is_empty: 1'b0, is_full: 1'b0};
    case (m)
      MODE_ENQ: begin
        if (q_fill >= q_cap) begin
          r.status = ST_FULL;
        end else begin
          q_slots[q_tail] = v;
          q_tail = ring_advance(q_tail);
          q_fill++;
        end
      end
      MODE_DEQ: begin
        if (q_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = q_slots[q_head];
          q_head = ring_advance(q_head);
          q_fill--;
        end
      end
      MODE_PEEK: begin
        if (q_fill == 0) r.status = ST_EMPTY;
        else r.data = q_slots[q_head];
      end
      MODE_CLR: begin
        q_head = 0;
        q_tail = 0;
        q_fill = 0;
      end
      MODE_SRCH: begin
        r.status = ST_NOTFOUND;
        p = q_head;
        hit = 1'b0;
        for (int k = 0; k < q_fill && !hit; k++) begin
          if (q_slots[p] == v) begin
            hit = 1'b1;
            r.status = ST_OK;
            r.slot = slot_t'(p);
          end else begin
            p = ring_advance(p);
          end
        end
      end
      default: ;
    endcase
    r.count    = cap_t'(q_fill);
    r.is_empty = (q_fill == 0);
    r.is_full  = (q_fill == q_cap);
    return r;
  endfunction

  function automatic row_t item_row(mode_t m, word_t v);
    row_t r;
    r = '{is_cfg: 1'b0, cfg: '0, mode: m, value: v, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t typed_row(mode_t m, word_t v, status_t st, word_t d, slot_t s,
                                     cap_t cnt, logic e, logic f);
    row_t r;
    r = item_row(m, v);
    r.typed = 1'b1;
    r.want = '{status: st, data: d, slot: s, count: cnt, is_empty: e, is_full: f};
    return r;
  endfunction

  function automatic row_t cfg_row(cap_t c);
    row_t r;
    r = item_row(MODE_ENQ, '0);
    r.is_cfg = 1'b1;
    r.cfg = c;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response transfer with nothing outstanding");
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, rsp_if.status);
        check_field("data", want.data, rsp_if.data);
        check_field("slot", want.slot, rsp_if.slot);
        check_field("count", want.count, rsp_if.count);
        check_field("is_empty", want.is_empty, rsp_if.is_empty);
        check_field("is_full", want.is_full, rsp_if.is_full);
      end
    end
  end

  task automatic send_request(mode_t m, word_t v, bit typed, response_t typed_want);
    response_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.mode  = m;
    req_if.value = v;
    do @(posedge clk); while (!req_if.ready);
    want = predict_response(m, v);
    pending_rsp.push_back(typed ? typed_want : want);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(cap_t c);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = c;
    @(posedge clk);
    queue_reinit(c);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int    pick;
    mode_t m;
    word_t v;
    pick = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 7)) : word_t'($urandom);
    if (pick < 35) m = MODE_ENQ;
    else if (pick < 55) m = MODE_DEQ;
    else if (pick < 65) m = MODE_PEEK;
    else if (pick < 70) m = MODE_CLR;
    else if (pick < 95) m = MODE_SRCH;
    else m = mode_t'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
    // mostly search for a live word so hits land on every position
    if (m == MODE_SRCH && q_fill > 0 && $urandom_range(0, 9) < 7)
      v = q_slots[(q_head + $urandom_range(0, q_fill - 1)) % q_cap];
    send_request(m, v, 1'b0, '0);
  endtask

  initial begin
    cycle_count     = 0;
    error_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req_if.valid    = 1'b0;
    req_if.mode     = MODE_ENQ;
    req_if.value    = '0;
    foreach (q_slots[i]) q_slots[i] = '0;
    queue_reinit(cap_t'(DEPTH_DEF));
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    dir_rows.push_back(typed_row(MODE_DEQ, 32'sh0, ST_EMPTY, '0, '0, 5'd0, 1'b1, 1'b0));
    dir_rows.push_back(typed_row(MODE_PEEK, 32'sh0, ST_EMPTY, '0, '0, 5'd0, 1'b1, 1'b0));
    dir_rows.push_back(typed_row(MODE_SRCH, 32'sh0, ST_NOTFOUND, '0, '0, 5'd0, 1'b1, 1'b0));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'sh7fffffff, ST_OK, '0, '0, 5'd1, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'sh80000000, ST_OK, '0, '0, 5'd2, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(MODE_SRCH, 32'sh80000000, ST_OK, '0, 4'd1, 5'd2, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(MODE_PEEK, 32'sh0, ST_OK, 32'sh7fffffff, '0, 5'd2, 1'b0,
                                 1'b0));
    dir_rows.push_back(typed_row(MODE_RSVD_LO, 32'sh0, ST_OK, '0, '0, 5'd2, 1'b0, 1'b0));
    dir_rows.push_back(typed_row(MODE_RSVD_HI, 32'shffffffff, ST_OK, '0, '0, 5'd2, 1'b0,
                                 1'b0));
    dir_rows.push_back(typed_row(MODE_DEQ, 32'shffffffff, ST_OK, 32'sh7fffffff, '0, 5'd1,
                                 1'b0, 1'b0));
    dir_rows.push_back(typed_row(MODE_CLR, 32'sh12345678, ST_OK, '0, '0, 5'd0, 1'b1, 1'b0));
    // zero capacity reads as one
    dir_rows.push_back(cfg_row(5'd0));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'shffffffff, ST_OK, '0, '0, 5'd1, 1'b0, 1'b1));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'sh5, ST_FULL, '0, '0, 5'd1, 1'b0, 1'b1));
    dir_rows.push_back(typed_row(MODE_SRCH, 32'shffffffff, ST_OK, '0, '0, 5'd1, 1'b0, 1'b1));
    dir_rows.push_back(typed_row(MODE_DEQ, 32'sh0, ST_OK, 32'shffffffff, '0, 5'd0, 1'b1,
                                 1'b0));
    // oversize capacity clamps to depth; a later write empties a non-empty queue
    dir_rows.push_back(cfg_row(5'd31));
    dir_rows.push_back(item_row(MODE_ENQ, 32'sh0));
    dir_rows.push_back(cfg_row(5'd3));
    dir_rows.push_back(item_row(MODE_ENQ, 32'sh1));
    dir_rows.push_back(item_row(MODE_ENQ, 32'sh2));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'sh3, ST_OK, '0, '0, 5'd3, 1'b0, 1'b1));
    dir_rows.push_back(typed_row(MODE_ENQ, 32'sh9, ST_FULL, '0, '0, 5'd3, 1'b0, 1'b1));
    dir_rows.push_back(item_row(MODE_DEQ, 32'sh0));
    dir_rows.push_back(item_row(MODE_ENQ, 32'sh4));
    dir_rows.push_back(item_row(MODE_SRCH, 32'sh4));
    dir_rows.push_back(item_row(MODE_SRCH, 32'sh2));
    dir_rows.push_back(item_row(MODE_SRCH, 32'sh63));
    dir_rows.push_back(item_row(MODE_RSVD_MID, 32'sh0));
    dir_rows.push_back(item_row(MODE_PEEK, 32'sh0));

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) write_capacity(dir_rows[r].cfg);
      else send_request(dir_rows[r].mode, dir_rows[r].value, dir_rows[r].typed,
                        dir_rows[r].want);
    end

    phase_caps[PHASES-1] = cap_t'($urandom_range(1, DEPTH_DEF));
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = idle_send[ph % 4];
      recv_stall_pct  = idle_recv[ph % 4];
      write_capacity(phase_caps[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold off until the queue of outstanding responses is empty
        if ((ph == 2 && n == 40) || $urandom_range(0, 199) == 0) wait_drained();
        send_random();
      end
    end

    wait_drained();
    if (error_count == 0) begin
      $display("tb_ring_queue_with_search_unit: done, clean");
    end else begin
      $display("tb_ring_queue_with_search_unit: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
